/* sv/ordered_list_engine_assert.svh */
// assertion macros for the ordered list engine
// expects signals clk and rst_n in the scope of use
`ifndef ORDERED_LIST_ENGINE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_ASSERT_SVH

// checked on every edge once reset is released
`define OLE_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define OLE_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/ole_pkg.sv */
// shared types and constants of the ordered list engine
// no dependencies
package ole_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int POS_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // port field widths
  localparam int CMD_W = 3;
  localparam int VAL_W = 32;
  localparam int IDX_W = 5;
  localparam int STS_W = 2;
  localparam int SIZE_W = 5;
  localparam int REM_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_FIRST  = 3'd0,
    CMD_ADD_LAST   = 3'd1,
    CMD_INSERT_AT  = 3'd2,
    CMD_REMOVE_AT  = 3'd3,
    CMD_REMOVE_ALL = 3'd4,
    CMD_PEEK_FIRST = 3'd5,
    CMD_PEEK_LAST  = 3'd6
  } cmd_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK    = 2'd0,
    STS_INDEX = 2'd1,
    STS_EMPTY = 2'd2,
    STS_FULL  = 2'd3
  } status_t;

  // action broadcast along the cell chain
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [POS_W-1:0]  pos;
  } cell_ctl_t;

endpackage

/* sv/ordered_list_engine.sv */
// top level of the ordered list engine: command decode, scan sequencer,
// result register and the chain of list cells
// depends on ole_pkg, ole_cell and ordered_list_engine_assert.svh
//
//  channel  ports                                       direction
//  -------  ------------------------------------------  ---------
//  in       in_valid in_stall in_command in_value in_index   into block
//  out      out_valid out_stall out_status out_read_value
//           out_list_size out_removed_count              out of block
//
// add, insert, remove_at and peeks finish in the cycle their word is accepted;
// the result word is registered and shows up on the next cycle
// remove_all_equal walks the cell chain with a scan pointer, one entry per
// cycle while the result register is free (out_stall can hold the scan)
// while scanning, or while a finished result waits under out_stall, in_stall
// stays high
// rst_n (synchronous) empties the list; entry words are not cleared
module ordered_list_engine (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ole_pkg::CMD_W-1:0]  in_command,
  input  logic [ole_pkg::VAL_W-1:0]  in_value,
  input  logic [ole_pkg::IDX_W-1:0]  in_index,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [ole_pkg::STS_W-1:0]  out_status,
  output logic [ole_pkg::VAL_W-1:0]  out_read_value,
  output logic [ole_pkg::SIZE_W-1:0] out_list_size,
  output logic [ole_pkg::REM_W-1:0]  out_removed_count
);
  import ole_pkg::*;

  // one-hot sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  scan_pos_r, scan_pos_nxt;
  logic [REM_W-1:0]  removed_r, removed_nxt;
  logic [DATA_W-1:0] key_r, key_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [VAL_W-1:0]  res_value_r, res_value_nxt;
  logic [SIZE_W-1:0] res_size_r, res_size_nxt;
  logic [REM_W-1:0]  res_removed_r, res_removed_nxt;
  logic              res_load;

  logic              out_free;
  logic              in_accept;
  logic              scan_step;
  logic              scan_hit;

  // cell chain
  cell_ctl_t         ctl;
  logic [DATA_W-1:0] cell_word;
  logic [DATA_W-1:0] cell_q [CAPACITY];
  logic [CAPACITY-1:0] match_vec;
  logic [POS_W-1:0]  rd_sel;
  logic [DATA_W-1:0] rd_word;

  logic              is_empty;
  logic              is_full;

  // the result register frees up when nothing waits in it or it is taken now
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !out_free;
  assign in_accept = in_valid && !in_stall;
  assign scan_step = (state_r == ST_SCAN) && out_free;
  assign scan_hit  = match_vec[scan_pos_r[POS_W-1:0]];

  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == CNT_W'(CAPACITY));

  // compare word is the held key while scanning, else the new word
  assign cell_word = (state_r == ST_SCAN) ? key_r : in_value[DATA_W-1:0];

  // single read tap on the chain, for remove_at and the peeks
  always_comb begin
    case (cmd_t'(in_command))
      CMD_PEEK_FIRST: rd_sel = '0;
      CMD_PEEK_LAST:  rd_sel = POS_W'(count_r - CNT_W'(1));
      default:        rd_sel = in_index[POS_W-1:0];
    endcase
  end
  assign rd_word = cell_q[rd_sel];

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    scan_pos_nxt    = scan_pos_r;
    removed_nxt     = removed_r;
    key_nxt         = key_r;
    ctl.op          = CELL_HOLD;
    ctl.pos         = '0;
    res_load        = 1'b0;
    res_status_nxt  = res_status_r;
    res_value_nxt   = res_value_r;
    res_size_nxt    = res_size_r;
    res_removed_nxt = res_removed_r;

    if (in_accept) begin
      res_load        = 1'b1;
      res_status_nxt  = STS_OK;
      res_value_nxt   = '0;
      res_removed_nxt = '0;
      case (cmd_t'(in_command))
        CMD_ADD_FIRST, CMD_ADD_LAST: begin
          if (is_full) begin
            res_status_nxt = STS_FULL;
          end else begin
            ctl.op    = CELL_INS;
            ctl.pos   = (cmd_t'(in_command) == CMD_ADD_FIRST) ? '0 : count_r[POS_W-1:0];
            count_nxt = count_r + CNT_W'(1);
          end
        end
        CMD_INSERT_AT: begin
          if (CNT_W'(in_index) > count_r) begin
            res_status_nxt = STS_INDEX;
          end else if (is_full) begin
            res_status_nxt = STS_FULL;
          end else begin
            ctl.op    = CELL_INS;
            ctl.pos   = in_index[POS_W-1:0];
            count_nxt = count_r + CNT_W'(1);
          end
        end
        CMD_REMOVE_AT: begin
          if (is_empty) begin
            res_status_nxt = STS_EMPTY;
          end else if (CNT_W'(in_index) >= count_r) begin
            res_status_nxt = STS_INDEX;
          end else begin
            ctl.op          = CELL_DEL;
            ctl.pos         = in_index[POS_W-1:0];
            count_nxt       = count_r - CNT_W'(1);
            res_value_nxt   = VAL_W'(rd_word);
            res_removed_nxt = REM_W'(1);
          end
        end
        CMD_REMOVE_ALL: begin
          // empty list answers at once, otherwise the scan produces the result
          if (!is_empty) begin
            res_load     = 1'b0;
            state_nxt    = ST_SCAN;
            scan_pos_nxt = '0;
            removed_nxt  = '0;
            key_nxt      = in_value[DATA_W-1:0];
          end
        end
        CMD_PEEK_FIRST, CMD_PEEK_LAST: begin
          if (is_empty) begin
            res_status_nxt = STS_EMPTY;
          end else begin
            res_value_nxt = VAL_W'(rd_word);
          end
        end
        default: ;
      endcase
      res_size_nxt = SIZE_W'(count_nxt);
    end else if (scan_step) begin
      // drop the entry under the pointer on a hit, otherwise step past it
      if (scan_hit) begin
        ctl.op      = CELL_DEL;
        ctl.pos     = scan_pos_r[POS_W-1:0];
        count_nxt   = count_r - CNT_W'(1);
        removed_nxt = removed_r + REM_W'(1);
      end else begin
        scan_pos_nxt = scan_pos_r + CNT_W'(1);
      end
      if (scan_pos_nxt >= count_nxt) begin
        state_nxt       = ST_IDLE;
        res_load        = 1'b1;
        res_status_nxt  = STS_OK;
        res_value_nxt   = '0;
        res_size_nxt    = SIZE_W'(count_nxt);
        res_removed_nxt = removed_nxt;
      end
    end

    out_valid_nxt = (out_valid_r && out_stall) || res_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_pos_r    <= scan_pos_nxt;
    removed_r     <= removed_nxt;
    key_r         <= key_nxt;
    res_status_r  <= res_status_nxt;
    res_value_r   <= res_value_nxt;
    res_size_r    <= res_size_nxt;
    res_removed_r <= res_removed_nxt;
  end

  // the chain: each cell sees its neighbors; the ends see themselves
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_q;
    logic [DATA_W-1:0] right_q;
    if (i == 0) begin : g_head
      assign left_q = cell_q[i];
    end else begin : g_mid_l
      assign left_q = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_q = cell_q[i];
    end else begin : g_mid_r
      assign right_q = cell_q[i+1];
    end
    ole_cell u_cell (
      .clk      (clk),
      .cell_idx (POS_W'(i)),
      .ctl      (ctl),
      .word     (cell_word),
      .left_q   (left_q),
      .right_q  (right_q),
      .q        (cell_q[i]),
      .match    (match_vec[i])
    );
  end

  assign out_valid         = out_valid_r;
  assign out_status        = res_status_r;
  assign out_read_value    = res_value_r;
  assign out_list_size     = res_size_r;
  assign out_removed_count = res_removed_r;

`include "ordered_list_engine_assert.svh"

  `OLE_CHECK(a_count_bound, count_r <= CNT_W'(CAPACITY), "list size beyond capacity")
  `OLE_CHECK(a_scan_blocks_input, (state_r == ST_SCAN) |-> in_stall, "input open during scan")
  `OLE_CHECK(a_scan_hit_shrinks, (scan_step && scan_hit) |=> (count_r == $past(count_r) - CNT_W'(1)), "scan hit did not drop an entry")
  `OLE_CHECK(a_scan_pos_in_list, (state_r == ST_SCAN) |-> (scan_pos_r < count_r), "scan pointer past the list end")

endmodule

/* sv/ole_cell.sv */
// one list entry of the cell chain: holds, loads or takes a neighbor's word
// depends on ole_pkg
module ole_cell (
  input  logic                      clk,
  input  logic [ole_pkg::POS_W-1:0] cell_idx,
  input  ole_pkg::cell_ctl_t        ctl,
  input  logic [ole_pkg::DATA_W-1:0] word,
  input  logic [ole_pkg::DATA_W-1:0] left_q,
  input  logic [ole_pkg::DATA_W-1:0] right_q,
  output logic [ole_pkg::DATA_W-1:0] q,
  output logic                      match
);
  import ole_pkg::*;

  logic [DATA_W-1:0] q_r;
  logic [DATA_W-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    case (ctl.op)
      CELL_INS: begin
        if (cell_idx == ctl.pos) begin
          q_nxt = word;
        end else if (cell_idx > ctl.pos) begin
          q_nxt = left_q;
        end
      end
      CELL_DEL: begin
        if (cell_idx >= ctl.pos) begin
          q_nxt = right_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q     = q_r;
  assign match = (q_r == word);

endmodule

/* tb/tb_ordered_list_engine.sv */
// self-checking testbench for the ordered list engine: directed corner cases, then
// random command streams under four sender and receiver idling mixes
// depends on ole_pkg and the ordered_list_engine RTL
`timescale 1ns / 1ps

module tb_ordered_list_engine;
  import ole_pkg::*;

  // random words per idling mix, run limit, settle time after the last result
  localparam int ITEMS_PER_PHASE = 300;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int SETTLE_CYCLES   = 40;
  // the one command code the block treats as a no-op
  localparam logic [CMD_W-1:0] CMD_NOP = 3'd7;

  // one command word as the sender presents it
  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [VAL_W-1:0] val;
    logic [IDX_W-1:0] idx;
  } list_cmd_t;

  // one result word as the block should return it
  typedef struct {
    status_t           status;
    logic [VAL_W-1:0]  read_value;
    logic [SIZE_W-1:0] size;
    logic [REM_W-1:0]  removed;
  } list_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [CMD_W-1:0] in_command = '0;
  logic [VAL_W-1:0] in_value = '0;
  logic [IDX_W-1:0] in_index = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic [STS_W-1:0] out_status;
  logic [VAL_W-1:0] out_read_value;
  logic [SIZE_W-1:0] out_list_size;
  logic [REM_W-1:0] out_removed_count;

  // words waiting to be driven, and replies owed by the block, oldest first
  list_cmd_t   pending_cmds[$];
  list_reply_t owed_replies[$];

  // shadow copy of the list, head at position 0
  logic [VAL_W-1:0] shadow_words[CAPACITY];
  int unsigned      shadow_len = 0;

  int unsigned queued_count = 0;
  int unsigned taken_count = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  logic        word_taken = 1'b0;

  // idling mix of the current phase, in percent per cycle
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;

  // a handful of recurring values so remove_all_equal finds several copies
  logic [VAL_W-1:0] value_pool[6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                      32'h8000_0000, 32'h5A5A_5A5A, 32'hA5A5_A5A5};

  ordered_list_engine DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_value          (in_value),
    .in_index          (in_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_read_value    (out_read_value),
    .out_list_size     (out_list_size),
    .out_removed_count (out_removed_count)
  );

  always #5 clk = ~clk;

  // open a slot at pos by shifting the tail back one place
  function automatic void shadow_insert(input int unsigned pos, input logic [VAL_W-1:0] w);
    int unsigned i;
    for (i = shadow_len; i > pos; i--) shadow_words[i] = shadow_words[i-1];
    shadow_words[pos] = w;
    shadow_len++;
  endfunction

  // apply one command to the shadow list and return the reply it must produce
  function automatic list_reply_t list_step(input list_cmd_t c);
    list_reply_t r;
    int unsigned i;
    int unsigned keep;
    r.status     = STS_OK;
    r.read_value = '0;
    r.removed    = '0;
    case (c.cmd)
      CMD_ADD_FIRST, CMD_ADD_LAST: begin
        if (shadow_len >= CAPACITY) r.status = STS_FULL;
        else shadow_insert((c.cmd == CMD_ADD_FIRST) ? 0 : shadow_len, c.val);
      end
      CMD_INSERT_AT: begin
        // index is judged before fullness
        if (c.idx > shadow_len) r.status = STS_INDEX;
        else if (shadow_len >= CAPACITY) r.status = STS_FULL;
        else shadow_insert(c.idx, c.val);
      end
      CMD_REMOVE_AT: begin
        // an empty list wins over a bad index
        if (shadow_len == 0) r.status = STS_EMPTY;
        else if (c.idx >= shadow_len) r.status = STS_INDEX;
        else begin
          r.read_value = shadow_words[c.idx];
          for (i = c.idx; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i+1];
          shadow_len--;
          r.removed = 1;
        end
      end
      CMD_REMOVE_ALL: begin
        // compact survivors toward the head; an empty list just reports zero
        keep = 0;
        for (i = 0; i < shadow_len; i++) begin
          if (shadow_words[i] == c.val) r.removed = r.removed + 1'b1;
          else begin
            shadow_words[keep] = shadow_words[i];
            keep++;
          end
        end
        shadow_len = keep;
      end
      CMD_PEEK_FIRST, CMD_PEEK_LAST: begin
        if (shadow_len == 0) r.status = STS_EMPTY;
        else r.read_value = shadow_words[(c.cmd == CMD_PEEK_FIRST) ? 0 : shadow_len - 1];
      end
      default: ;  // unused code: nothing changes
    endcase
    r.size = shadow_len[SIZE_W-1:0];
    return r;
  endfunction

  task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val,
                           input logic [IDX_W-1:0] idx);
    list_cmd_t c;
    c.cmd = cmd;
    c.val = val;
    c.idx = idx;
    pending_cmds.push_back(c);
    queued_count++;
  endtask

  // random commands in stretches of 40 that lean toward filling, emptying, or neither,
  // so the list keeps swinging between empty and full
  task automatic queue_random(input int unsigned n);
    int unsigned k;
    int unsigned r;
    int unsigned lean;
    logic [CMD_W-1:0] cmd;
    logic [VAL_W-1:0] val;
    logic [IDX_W-1:0] idx;
    for (k = 0; k < n; k++) begin
      lean = (k / 40) % 3;
      r = $urandom_range(0, 99);
      if (lean == 0) begin
        // filling
        if (r < 25) cmd = CMD_ADD_FIRST;
        else if (r < 50) cmd = CMD_ADD_LAST;
        else if (r < 75) cmd = CMD_INSERT_AT;
        else if (r < 83) cmd = CMD_REMOVE_AT;
        else if (r < 86) cmd = CMD_REMOVE_ALL;
        else if (r < 92) cmd = CMD_PEEK_FIRST;
        else if (r < 98) cmd = CMD_PEEK_LAST;
        else cmd = CMD_NOP;
      end else if (lean == 1) begin
        // draining
        if (r < 8) cmd = CMD_ADD_FIRST;
        else if (r < 16) cmd = CMD_ADD_LAST;
        else if (r < 24) cmd = CMD_INSERT_AT;
        else if (r < 62) cmd = CMD_REMOVE_AT;
        else if (r < 78) cmd = CMD_REMOVE_ALL;
        else if (r < 88) cmd = CMD_PEEK_FIRST;
        else if (r < 98) cmd = CMD_PEEK_LAST;
        else cmd = CMD_NOP;
      end else begin
        cmd = CMD_W'($urandom_range(0, 6));
        if (r < 3) cmd = CMD_NOP;
      end
      r = $urandom_range(0, 99);
      if (r < 60) val = value_pool[3'($urandom_range(0, 5))];
      else val = $urandom();
      r = $urandom_range(0, 99);
      if (r < 10) idx = 0;
      else if (r < 92) idx = IDX_W'($urandom_range(0, CAPACITY));
      else idx = IDX_W'($urandom_range(CAPACITY + 1, 31));
      queue_cmd(cmd, val, idx);
    end
  endtask

  // hold off until every queued word is taken and every reply has come back
  task automatic wait_for_quiet();
    while (taken_count != queued_count || owed_replies.size() != 0) @(posedge clk);
  endtask

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // driver: new word or idle at the falling edge; a word stays put until taken
  always @(negedge clk) begin
    list_cmd_t c;
    logic      send;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      send = pending_cmds.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct;
      if (send) begin
        c = pending_cmds.pop_front();
        in_command <= c.cmd;
        in_value   <= c.val;
        in_index   <= c.idx;
        in_valid   <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= rst_n && ($urandom_range(0, 99) < receiver_stall_pct);
  end

  // monitor: check the result word first (it always belongs to an older command),
  // then book the reply owed for a command taken at this edge
  always @(posedge clk) begin
    list_reply_t want;
    list_cmd_t   c;
    if (rst_n && out_valid && !out_stall) begin
      if (owed_replies.size() == 0) begin
        $error("result word with nothing expected: status %0d read_value %h size %0d",
               out_status, out_read_value, out_list_size);
        mismatches++;
      end else begin
        want = owed_replies.pop_front();
        if (out_status !== want.status) begin
          $error("out_status: expected %0d, got %0d", want.status, out_status);
          mismatches++;
        end
        if (out_read_value !== want.read_value) begin
          $error("out_read_value: expected %h, got %h", want.read_value, out_read_value);
          mismatches++;
        end
        if (out_list_size !== want.size) begin
          $error("out_list_size: expected %0d, got %0d", want.size, out_list_size);
          mismatches++;
        end
        if (out_removed_count !== want.removed) begin
          $error("out_removed_count: expected %0d, got %0d", want.removed, out_removed_count);
          mismatches++;
        end
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      c.cmd = in_command;
      c.val = in_value;
      c.idx = in_index;
      owed_replies.push_back(list_step(c));
      taken_count = taken_count + 1;
      word_taken <= 1'b1;
    end else begin
      word_taken <= 1'b0;
    end
  end

  // stimulus and end of run
  initial begin
    int unsigned k;
    // empty list corners, then the no-op code
    queue_cmd(CMD_PEEK_FIRST, 32'h1234_5678, 0);
    queue_cmd(CMD_PEEK_LAST, 32'h0, 0);
    queue_cmd(CMD_REMOVE_AT, 32'h0, 31);
    queue_cmd(CMD_REMOVE_ALL, 32'h0, 0);
    queue_cmd(CMD_NOP, 32'hFFFF_FFFF, 31);
    // grow with the value extremes, insert at the end and past it
    queue_cmd(CMD_ADD_FIRST, 32'h0000_0000, 0);
    queue_cmd(CMD_ADD_LAST, 32'hFFFF_FFFF, 0);
    queue_cmd(CMD_INSERT_AT, 32'hA5A5_A5A5, 2);
    queue_cmd(CMD_INSERT_AT, 32'h1111_1111, 4);
    queue_cmd(CMD_INSERT_AT, 32'hA5A5_A5A5, 0);
    queue_cmd(CMD_REMOVE_AT, 32'h0, 4);
    // fill to capacity, then hit the full list every way
    for (k = 0; k < CAPACITY - 4; k++) queue_cmd(CMD_ADD_FIRST, 32'hA5A5_A5A5, 0);
    queue_cmd(CMD_ADD_FIRST, 32'h2222_2222, 0);
    queue_cmd(CMD_ADD_LAST, 32'h2222_2222, 0);
    queue_cmd(CMD_INSERT_AT, 32'h2222_2222, 16);
    queue_cmd(CMD_INSERT_AT, 32'h2222_2222, 17);
    queue_cmd(CMD_PEEK_LAST, 32'h0, 0);
    // pop the tail, then clear most of the list in one sweep
    queue_cmd(CMD_REMOVE_AT, 32'h0, 15);
    queue_cmd(CMD_REMOVE_ALL, 32'hA5A5_A5A5, 0);
    queue_random(ITEMS_PER_PHASE);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // no idling on either side
    wait_for_quiet();
    // sender idles often; each phase change waits for all replies first
    sender_idle_pct = 66;
    queue_random(ITEMS_PER_PHASE);
    wait_for_quiet();
    // receiver stalls often
    sender_idle_pct = 0;
    receiver_stall_pct = 66;
    queue_random(ITEMS_PER_PHASE);
    wait_for_quiet();
    // both sides gap now and then
    sender_idle_pct = 30;
    receiver_stall_pct = 30;
    queue_random(ITEMS_PER_PHASE);
    wait_for_quiet();

    // give any stray result word time to show up
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && owed_replies.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
